>>> src/bapq_pkg.sv
`timescale 1ns / 1ps

package bapq_pkg;

  // palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);

  // field widths
  localparam int COLOR_W    = 8;
  localparam int PIXEL_W    = 32;
  localparam int COUNT_W    = 9;
  localparam int DIST_W     = 18;
  localparam int BEST_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [BEST_W-1:0]  DIST_INIT       = BEST_W'(255 * 255 * 255);
  localparam logic [COUNT_W-1:0] DEPTH_COUNT     = COUNT_W'(PALETTE_DEPTH);
  localparam logic [COUNT_W-1:0] CFG_COUNT_RESET = COUNT_W'(256);

  // request commands
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_QUANTIZE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_IDX   = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] color_count;
    logic               trans_en;
    logic [COLOR_W-1:0] trans_idx;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

endpackage

>>> src/bapq_palette_ram.sv
`timescale 1ns / 1ps

module bapq_palette_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/bapq_search.sv
`timescale 1ns / 1ps

module bapq_search
  import bapq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PIXEL_W-1:0] px_tl,
  input  logic [PIXEL_W-1:0] px_tr,
  input  logic [PIXEL_W-1:0] px_bl,
  input  logic [PIXEL_W-1:0] px_br,
  input  cfg_t               cfg,
  output logic               idle,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  input  rgb_t               rd_data,
  output logic               res_valid,
  output logic [COLOR_W-1:0] res_index,
  input  logic               res_take
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t             state;
  logic [COUNT_W-1:0] ptr;
  logic [COUNT_W-1:0] limit;
  rgb_t               target;
  logic               p1_valid;
  logic [COLOR_W-1:0] p1_idx;
  logic               p2_valid;
  logic [COLOR_W-1:0] p2_idx;
  logic [DIST_W-1:0]  p2_dist;
  logic [COLOR_W-1:0] best_idx;
  logic [BEST_W-1:0]  best_dist;

  logic [COLOR_W-1:0] avg_a;
  rgb_t               avg_rgb;
  logic [COUNT_W-1:0] limit_now;
  logic               issue;
  logic               elig;
  logic [DIST_W-1:0]  cand_dist;

  function automatic logic [COLOR_W-1:0] avg4(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b,
                                               input logic [COLOR_W-1:0] c,
                                               input logic [COLOR_W-1:0] d);
    logic [COLOR_W+1:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return s[COLOR_W+1:2];
  endfunction

  function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{COLOR_W{1'b0}}, d} * {{COLOR_W{1'b0}}, d};
  endfunction

  // box average of the four pixels in each byte lane, and the color count clipped to the palette depth
  always_comb begin
    avg_a         = avg4(px_tl[31:24], px_tr[31:24], px_bl[31:24], px_br[31:24]);
    avg_rgb.red   = avg4(px_tl[23:16], px_tr[23:16], px_bl[23:16], px_br[23:16]);
    avg_rgb.green = avg4(px_tl[15:8],  px_tr[15:8],  px_bl[15:8],  px_br[15:8]);
    avg_rgb.blue  = avg4(px_tl[7:0],   px_tr[7:0],   px_bl[7:0],   px_br[7:0]);
    limit_now     = (cfg.color_count > DEPTH_COUNT) ? DEPTH_COUNT : cfg.color_count;
  end

  assign issue   = (state == S_SCAN);
  assign rd_en   = issue;
  assign rd_addr = ptr[IDX_W-1:0];
  assign elig    = !(cfg.trans_en && (ptr[COLOR_W-1:0] == cfg.trans_idx));

  assign cand_dist = {2'b00, sq_diff(target.red,   rd_data.red)}
                   + {2'b00, sq_diff(target.green, rd_data.green)}
                   + {2'b00, sq_diff(target.blue,  rd_data.blue)};

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_index = best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      // read -> distance -> compare
      p1_valid <= issue && elig;
      p1_idx   <= ptr[COLOR_W-1:0];
      p2_valid <= p1_valid;
      p2_idx   <= p1_idx;
      p2_dist  <= cand_dist;
      if (p2_valid && ({{(BEST_W-DIST_W){1'b0}}, p2_dist} < best_dist)) begin
        best_idx  <= p2_idx;
        best_dist <= {{(BEST_W-DIST_W){1'b0}}, p2_dist};
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            target    <= avg_rgb;
            ptr       <= '0;
            limit     <= limit_now;
            best_dist <= DIST_INIT;
            if (cfg.trans_en && (avg_a == '0)) begin
              best_idx <= cfg.trans_idx;
              state    <= S_DONE;
            end else if (limit_now == '0) begin
              best_idx <= '0;
              state    <= S_DONE;
            end else begin
              best_idx <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          ptr <= ptr + COUNT_W'(1);
          if (ptr == limit - COUNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!p1_valid && !p2_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/box_average_palette_quantizer.sv
`timescale 1ns / 1ps

// box-average palette quantizer: a load request (cmd 0) writes one 24-bit rgb
// entry into the palette memory and gives no result; a quantize request
// (cmd 1) averages a 2x2 block of argb pixels per channel (truncating) and
// answers with one color_index: the transparent index when transparency is on
// and the averaged alpha is zero, otherwise the first palette entry of
// 0..color_count-1 (transparent index skipped) with the smallest squared rgb
// distance, or 0 when nothing is eligible. the search reads the palette
// memory one entry per clock over the searched count (color_count, at most
// 256), and the transparent or empty path skips the search; the result
// enters the output register once that register is free. one request is in
// flight at a time; a finished result
// sits in the output register, so the next request is taken while it waits.
// palette entries read before they are written return unspecified colors.
// configuration writes take effect at once and are meant for idle periods only.

module box_average_palette_quantizer
  import bapq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [COLOR_W-1:0]    entry_index,
  input  logic [COLOR_W-1:0]    entry_red,
  input  logic [COLOR_W-1:0]    entry_green,
  input  logic [COLOR_W-1:0]    entry_blue,
  input  logic [PIXEL_W-1:0]    pixel_top_left,
  input  logic [PIXEL_W-1:0]    pixel_top_right,
  input  logic [PIXEL_W-1:0]    pixel_bottom_left,
  input  logic [PIXEL_W-1:0]    pixel_bottom_right,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_W-1:0]    color_index,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg;
  logic               accept;
  logic               load_we;
  logic               start;
  logic               eng_idle;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  rgb_t               rd_data;
  rgb_t               wr_data;
  logic               res_valid;
  logic [COLOR_W-1:0] res_index;
  logic               res_take;

  // configuration registers, writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_count <= CFG_COUNT_RESET;
      cfg.trans_en    <= 1'b0;
      cfg.trans_idx   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_COUNT: cfg.color_count <= cfg_data[COUNT_W-1:0];
        REG_TRANS_EN:    cfg.trans_en    <= cfg_data[0];
        REG_TRANS_IDX:   cfg.trans_idx   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // a request is taken whenever the search engine is free
  assign in_ready = eng_idle;
  assign accept   = in_valid && in_ready;
  assign start    = accept && (cmd == CMD_QUANTIZE);

  // loads beyond the palette are ignored
  assign load_we = accept && (cmd == CMD_LOAD)
                && ({1'b0, entry_index} < DEPTH_COUNT);

  assign wr_data.red   = entry_red;
  assign wr_data.green = entry_green;
  assign wr_data.blue  = entry_blue;

  // a load finishes in its own accept cycle and the search starts later, so
  // a read never overlaps a write of the same entry
  bapq_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .WIDTH ($bits(rgb_t))
  ) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (entry_index[IDX_W-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bapq_search u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .px_tl     (pixel_top_left),
    .px_tr     (pixel_top_right),
    .px_bl     (pixel_bottom_left),
    .px_br     (pixel_bottom_right),
    .cfg       (cfg),
    .idle      (eng_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_index (res_index),
    .res_take  (res_take)
  );

  // output register, refilled in the cycle it drains
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      color_index <= res_index;
    end
  end

endmodule

>>> src/bapq_checker.sv
`timescale 1ns / 1ps

module bapq_checker
  import bapq_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  cmd,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COLOR_W-1:0]    color_index
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_index))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a quantize request occupies the block
  a_quant_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_QUANTIZE) |=> !in_ready)
    else $error("request taken while search busy");

  // a load makes no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_LOAD) && !out_valid |=> !out_valid)
    else $error("load produced a result");

endmodule

bind box_average_palette_quantizer bapq_checker u_bapq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .cmd         (cmd),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .color_index (color_index)
);
